[rtl/core/acs_pkg.sv]
// ----------------------------------------------------------------------------
// acs_pkg
// shared types and constants of the acceleration segment slicer
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int MAX_SLICES_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CHUNK_W        = 16;
  localparam int CFG_IDX_W      = 1;

  localparam logic [31:0] SLICE_INTERVAL_RST = 32'd655;
  localparam logic [31:0] COAST_INTERVAL_RST = 32'd65536;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLICE_INTERVAL = 1'b0,
    REG_COAST_INTERVAL = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]        seg_duration;
    logic [31:0]        seg_start;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic signed [31:0] speed_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        slice_begin;
    logic [31:0]        slice_length;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic signed [31:0] end_vx;
    logic signed [31:0] end_vy;
    logic signed [31:0] end_vz;
    logic               last_slice;
    logic               truncated;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MUL,
    S_FIN,
    S_SUM,
    S_EMIT
  } seq_state_t;

  // product jobs run on the shared multiplier
  typedef enum logic [1:0] {
    JOB_TT,
    JOB_VT,
    JOB_AT,
    JOB_AH
  } job_t;

  // multiplier control from the sequencer
  typedef struct packed {
    logic step;
    logic clr;
  } mul_ctl_t;

endpackage

[rtl/core/acs_mul.sv]
// ----------------------------------------------------------------------------
// acs_mul
// shared signed by unsigned multiplier, one 16-bit chunk of u per cycle while ctl.step
// ----------------------------------------------------------------------------
module acs_mul #(
  parameter int FRAC_BITS = acs_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  acs_pkg::mul_ctl_t                      ctl,
  input  logic [$clog2((63-FRAC_BITS+15)/16)-1:0] chunk,
  input  logic signed [32:0]                     op_k,
  input  logic [63-FRAC_BITS-1:0]                op_u,
  output logic signed [33+((63-FRAC_BITS+15)/16)*16-1:0] acc
);
  import acs_pkg::*;

  localparam int U_W    = 63 - FRAC_BITS;
  localparam int NCHUNK = (U_W + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W  = NCHUNK * CHUNK_W;
  localparam int AW     = 33 + PAD_W;
  localparam int PP_W   = 33 + CHUNK_W + 1;

  logic [PAD_W-1:0]         u_pad;
  logic [CHUNK_W-1:0]       u_sel;
  logic signed [PP_W-1:0]   pp;
  logic signed [AW-1:0]     pp_sh;
  logic signed [AW-1:0]     acc_r;
  logic signed [AW-1:0]     acc_nxt;

  // partial product of one chunk, placed at its weight
  assign u_pad = {{(PAD_W-U_W){1'b0}}, op_u};
  assign u_sel = u_pad[chunk*CHUNK_W +: CHUNK_W];
  assign pp    = op_k * $signed({1'b0, u_sel});
  assign pp_sh = {{(AW-PP_W){pp[PP_W-1]}}, pp} <<< (int'(chunk) * CHUNK_W);

  // accumulate
  assign acc_nxt = (ctl.clr ? '0 : acc_r) + pp_sh;

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

[rtl/core/acs_seq.sv]
// ----------------------------------------------------------------------------
// acs_seq
// slice sequencer: walks the segment, schedules products, forms results
// ----------------------------------------------------------------------------
module acs_seq #(
  parameter int MAX_SLICES = acs_pkg::MAX_SLICES_DEF,
  parameter int FRAC_BITS  = acs_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  acs_pkg::in_item_t  in_data,
  input  logic [31:0]        slice_interval,
  input  logic [31:0]        coast_interval,
  output logic               emit_valid,
  input  logic               emit_take,
  output acs_pkg::out_item_t emit_data
);
  import acs_pkg::*;

  localparam int U_W    = 63 - FRAC_BITS;
  localparam int NCHUNK = (U_W + CHUNK_W - 1) / CHUNK_W;
  localparam int CW     = $clog2(NCHUNK);
  localparam int AW     = 33 + NCHUNK * CHUNK_W;
  localparam int CNT_W  = $clog2(MAX_SLICES + 1);

  seq_state_t state_r, state_nxt;
  job_t       job_r;
  logic [1:0] axis_r;
  logic [CW-1:0] chunk_r;
  logic [CNT_W-1:0] cnt_r;
  logic [31:0] offset_r, len_r, t_r, begin_r, step_r;
  logic [U_W-1:0] half_r;
  logic last_r, trunc_r;
  in_item_t item_r;
  logic signed [31:0] term_vt_r, term_at_r, term_ah_r;
  logic signed [31:0] pos_r [3];
  logic signed [31:0] vel_r [3];

  logic signed [31:0] p0 [3];
  logic signed [31:0] v0 [3];
  logic signed [31:0] ac [3];

  mul_ctl_t mul_ctl;
  logic signed [32:0] op_k;
  logic [U_W-1:0] op_u;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] acc_sh;
  logic signed [31:0] prod_sat;
  logic chunk_done;

  logic [31:0] rem, len_c, t_c, step_c;
  logic [32:0] begin_c;
  logic last_c, trunc_c, accel_zero;
  logic signed [33:0] psum, vsum;
  logic accept;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      sat34 = v[31:0];
    end else if (v[33]) begin
      sat34 = 32'sh8000_0000;
    end else begin
      sat34 = 32'sh7fff_ffff;
    end
  endfunction

  assign p0[0] = item_r.start_x;
  assign p0[1] = item_r.start_y;
  assign p0[2] = item_r.start_z;
  assign v0[0] = item_r.speed_x;
  assign v0[1] = item_r.speed_y;
  assign v0[2] = item_r.speed_z;
  assign ac[0] = item_r.accel_x;
  assign ac[1] = item_r.accel_y;
  assign ac[2] = item_r.accel_z;

  // step length chosen at transfer
  assign accel_zero = (in_data.accel_x == '0) && (in_data.accel_y == '0) &&
                      (in_data.accel_z == '0);
  assign step_c = (accel_zero ? coast_interval : slice_interval) == '0 ? 32'd1 :
                  (accel_zero ? coast_interval : slice_interval);
  assign accept = in_valid && !in_stall;

  // slice bounds
  assign rem     = item_r.seg_duration - offset_r;
  assign len_c   = (rem > step_r) ? step_r : rem;
  assign t_c     = offset_r + len_c;
  assign begin_c = {1'b0, item_r.seg_start} + {1'b0, offset_r};
  assign last_c  = (t_c == item_r.seg_duration);
  assign trunc_c = !last_c && (({1'b0, cnt_r} + 1'b1) == (CNT_W+1)'(MAX_SLICES));

  // operand selection for the shared multiplier
  always_comb begin
    unique case (job_r)
      JOB_TT: begin
        op_k = $signed({1'b0, t_r});
        op_u = U_W'(t_r);
      end
      JOB_VT: begin
        op_k = 33'(v0[axis_r]);
        op_u = U_W'(t_r);
      end
      JOB_AT: begin
        op_k = 33'(ac[axis_r]);
        op_u = U_W'(t_r);
      end
      default: begin
        op_k = 33'(ac[axis_r]);
        op_u = half_r;
      end
    endcase
  end

  acs_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .ctl   (mul_ctl),
    .chunk (chunk_r),
    .op_k  (op_k),
    .op_u  (op_u),
    .acc   (acc)
  );

  // floor shift and saturate the finished product
  assign acc_sh = acc >>> FRAC_BITS;
  always_comb begin
    if (acc_sh[AW-1:31] == '0 || acc_sh[AW-1:31] == '1) begin
      prod_sat = acc_sh[31:0];
    end else if (acc_sh[AW-1]) begin
      prod_sat = 32'sh8000_0000;
    end else begin
      prod_sat = 32'sh7fff_ffff;
    end
  end

  assign chunk_done = (chunk_r == CW'(NCHUNK - 1));
  assign psum = 34'(p0[axis_r]) + 34'(term_vt_r) + 34'(term_ah_r);
  assign vsum = 34'(v0[axis_r]) + 34'(term_at_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && in_data.seg_duration != '0) state_nxt = S_SETUP;
      S_SETUP: state_nxt = S_MUL;
      S_MUL:   if (chunk_done) state_nxt = S_FIN;
      S_FIN:   state_nxt = (job_r == JOB_AH) ? S_SUM : S_MUL;
      S_SUM:   state_nxt = (axis_r == 2'd2) ? S_EMIT : S_MUL;
      S_EMIT:  if (emit_take) state_nxt = (last_r || trunc_r) ? S_IDLE : S_SETUP;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall    = (state_r != S_IDLE);
    emit_valid  = (state_r == S_EMIT);
    mul_ctl.step = (state_r == S_MUL);
    mul_ctl.clr  = (chunk_r == '0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      job_r    <= JOB_TT;
      axis_r   <= '0;
      chunk_r  <= '0;
      cnt_r    <= '0;
      offset_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            offset_r <= '0;
            cnt_r    <= '0;
          end
        end
        S_SETUP: begin
          job_r   <= JOB_TT;
          chunk_r <= '0;
        end
        S_MUL: begin
          chunk_r <= chunk_done ? '0 : chunk_r + 1'b1;
        end
        S_FIN: begin
          unique case (job_r)
            JOB_TT: begin
              job_r  <= JOB_VT;
              axis_r <= '0;
            end
            JOB_VT:  job_r <= JOB_AT;
            JOB_AT:  job_r <= JOB_AH;
            default: job_r <= JOB_AH;
          endcase
        end
        S_SUM: begin
          job_r  <= JOB_VT;
          axis_r <= (axis_r == 2'd2) ? 2'd0 : axis_r + 2'd1;
        end
        S_EMIT: begin
          if (emit_take) begin
            offset_r <= t_r;
            cnt_r    <= cnt_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      step_r <= step_c;
    end
    if (state_r == S_SETUP) begin
      len_r   <= len_c;
      t_r     <= t_c;
      begin_r <= begin_c[32] ? 32'hffff_ffff : begin_c[31:0];
      last_r  <= last_c;
      trunc_r <= trunc_c;
    end
    if (state_r == S_FIN) begin
      unique case (job_r)
        JOB_TT:  half_r    <= acc[FRAC_BITS+1 +: U_W];
        JOB_VT:  term_vt_r <= prod_sat;
        JOB_AT:  term_at_r <= prod_sat;
        default: term_ah_r <= prod_sat;
      endcase
    end
    if (state_r == S_SUM) begin
      pos_r[axis_r] <= sat34(psum);
      vel_r[axis_r] <= sat34(vsum);
    end
  end

  // result assembly
  always_comb begin
    emit_data.slice_begin  = begin_r;
    emit_data.slice_length = len_r;
    emit_data.end_x        = pos_r[0];
    emit_data.end_y        = pos_r[1];
    emit_data.end_z        = pos_r[2];
    emit_data.end_vx       = vel_r[0];
    emit_data.end_vy       = vel_r[1];
    emit_data.end_vz       = vel_r[2];
    emit_data.last_slice   = last_r || trunc_r;
    emit_data.truncated    = trunc_r;
  end

  // checks
  a_fin_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |-> $past(state_r) == S_MUL)
    else $error("finish step without multiply");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SLICES))
    else $error("slice count beyond limit");
  a_emit_next: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && emit_take |=> state_r == S_IDLE || state_r == S_SETUP)
    else $error("bad state after result transfer");
  a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> chunk_r <= CW'(NCHUNK - 1))
    else $error("chunk index out of range");

endmodule

[rtl/core/accel_segment_slicer.sv]
// ----------------------------------------------------------------------------
// accel_segment_slicer
// cuts constant-acceleration 3-axis segments into timed slices
// ----------------------------------------------------------------------------
// usage: a segment transfers on in_valid with in_stall low; in_stall stays
// high until the last slice of that segment has been handed to the output
// register. each slice comes out as one transfer on out_valid / out_stall.
// configuration writes (cfg_we, cfg_index, cfg_wdata) set slice_interval and
// coast_interval; the user must make them only while the block is idle, the
// block itself does not enforce this. steps: setup, the t*t product, then
// for each of 3 axes three products (v*t, a*t, a*t*t/2) and one sum, then
// the transfer into the output register. each product steps through the
// 16-bit chunks of the unsigned multiplier operand (3 at 16 fraction bits)
// on the single shared 33x17 multiplier; up to 64 slices per segment. a zero
// duration segment is accepted and produces no slice.
// reset: registers return to their reset values, no result pending.
// stall: a slice waiting in the output register holds the sequencer in its
// result step until the receiver takes it.
// ----------------------------------------------------------------------------
module accel_segment_slicer #(
  parameter int MAX_SLICES = acs_pkg::MAX_SLICES_DEF,
  parameter int FRAC_BITS  = acs_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  acs_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output acs_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [acs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_wdata
);
  import acs_pkg::*;

  logic [31:0] slice_interval_r, coast_interval_r;
  logic        out_valid_r;
  out_item_t   out_r;
  logic        emit_valid, emit_take;
  out_item_t   emit_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_interval_r <= SLICE_INTERVAL_RST;
      coast_interval_r <= COAST_INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SLICE_INTERVAL: slice_interval_r <= cfg_wdata;
        REG_COAST_INTERVAL: coast_interval_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  acs_seq #(.MAX_SLICES(MAX_SLICES), .FRAC_BITS(FRAC_BITS)) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .slice_interval (slice_interval_r),
    .coast_interval (coast_interval_r),
    .emit_valid     (emit_valid),
    .emit_take      (emit_take),
    .emit_data      (emit_data)
  );

  // output register, refilled as soon as it empties
  assign emit_take = emit_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_take) begin
      out_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
